### src/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, codes and the Latin-1 fold table of the folded substring
// search block.
// ----------------------------------------------------------------------------
package fss_pkg;

  // needle store depth and derived widths
  localparam int NEEDLE_MAX = 32;
  localparam int LEN_W      = $clog2(NEEDLE_MAX + 1);

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_NEEDLE = 2'd1;
  localparam logic [1:0] CMD_HAY    = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic needle;
    logic hay;
    logic is_end;
    logic commit;
  } fss_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic has_result;
  } fss_sts_t;

  // fold table: merges case and strips most accents
  localparam logic [7:0] FOLD_TABLE [256] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f,
    8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'h40, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'h7e, 8'h7f,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f,
    8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
    8'h20, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'h7c, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'h2d, 8'hae, 8'haf,
    8'hb0, 8'hb1, 8'h32, 8'h33, 8'h27, 8'hb5, 8'hb6, 8'h2e,
    8'hb8, 8'h31, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'h3f,
    8'h61, 8'h61, 8'h61, 8'h61, 8'he4, 8'he5, 8'he6, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h64, 8'h6e, 8'h6f, 8'h6f, 8'h6f, 8'h6f, 8'hf6, 8'h78,
    8'hf8, 8'h75, 8'h75, 8'h75, 8'hfc, 8'h79, 8'hfe, 8'hdf,
    8'h61, 8'h61, 8'h61, 8'h61, 8'he4, 8'he5, 8'he6, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h64, 8'h6e, 8'h6f, 8'h6f, 8'h6f, 8'h6f, 8'hf6, 8'hf7,
    8'hf8, 8'h75, 8'h75, 8'h75, 8'hfc, 8'h79, 8'hfe, 8'h79
  };

endpackage

### src/fss_ctrl.sv
// ----------------------------------------------------------------------------
// fss_ctrl
// Controller: input handshake, evaluate state and result valid flag.
// ----------------------------------------------------------------------------
module fss_ctrl
  import fss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output fss_ctl_t   ctl,
  input  fss_sts_t   sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic state_r, state_nxt;
  logic eval_end_r, eval_end_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // decode commands and sequence the evaluate step
  always_comb begin
    state_nxt    = state_r;
    eval_end_nxt = eval_end_r;
    ctl          = '0;
    ctl.is_end   = eval_end_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.clear  = (in_command == CMD_CLEAR);
          ctl.needle = (in_command == CMD_NEEDLE);
          ctl.hay    = (in_command == CMD_HAY);
          if (in_command inside {CMD_HAY, CMD_END}) begin
            state_nxt    = S_EVAL;
            eval_end_nxt = (in_command == CMD_END);
          end
        end
      end
      S_EVAL: begin
        if (!sts.has_result) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // load or drop the result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eval_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eval_end_r  <= eval_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hay and end transactions always pass through the evaluate state
  a_eval_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command == CMD_HAY || in_command == CMD_END) |=> state_r == S_EVAL)
    else $error("evaluate state missed after hay or end transaction");

  // a new result appears only out of the evaluate state
  a_rise_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EVAL)
    else $error("result raised outside evaluate state");

  // never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

endmodule

### src/fss_datapath.sv
// ----------------------------------------------------------------------------
// fss_datapath
// Datapath: fold table, needle and hay shift lines, window compare,
// hay counter and result register.
// ----------------------------------------------------------------------------
module fss_datapath
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte_value,
  input  fss_ctl_t    ctl,
  output fss_sts_t    sts,
  output logic [1:0]  out_status,
  output logic [31:0] out_position
);

  // needle held newest first, so entry j lines up with window entry j
  logic [7:0]       needle_r [NEEDLE_MAX];
  logic [7:0]       window_r [NEEDLE_MAX];
  logic [LEN_W-1:0] needle_len_r;
  logic [31:0]      hay_count_r;
  logic             reported_r;
  logic             overflow_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_position_r;

  logic [7:0]            folded;
  logic [NEEDLE_MAX-1:0] lane_ok;
  logic                  window_hit;
  logic                  len_zero;
  logic                  needle_full;
  logic [1:0]            res_status;
  logic [31:0]           res_position;

  assign folded      = FOLD_TABLE[in_byte_value];
  assign len_zero    = (needle_len_r == '0);
  assign needle_full = (needle_len_r == LEN_W'(NEEDLE_MAX));

  // compare each window lane against its needle lane, unused lanes pass
  always_comb begin
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      lane_ok[j] = (LEN_W'(j) >= needle_len_r) || (window_r[j] == needle_r[j]);
    end
  end

  assign window_hit = (hay_count_r >= 32'(needle_len_r)) && (&lane_ok);

  // form the result of the pending hay or end transaction
  always_comb begin
    if (ctl.is_end) begin
      sts.has_result = !reported_r;
      res_status     = overflow_r ? ST_OVERFLOW : ST_NOT_FOUND;
      res_position   = '0;
    end else begin
      sts.has_result = !reported_r && !overflow_r && (len_zero || window_hit);
      res_status     = ST_FOUND;
      res_position   = len_zero ? '0 : (hay_count_r - 32'(needle_len_r));
    end
  end

  // shift in needle bytes; store has no reset
  always_ff @(posedge clk) begin
    if (ctl.needle && !needle_full) begin
      needle_r[0] <= folded;
      for (int j = 1; j < NEEDLE_MAX; j++) begin
        needle_r[j] <= needle_r[j-1];
      end
    end
  end

  // hay window, counters and job flags
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int j = 0; j < NEEDLE_MAX; j++) begin
        window_r[j] <= '0;
      end
      needle_len_r <= '0;
      hay_count_r  <= '0;
      reported_r   <= 1'b0;
      overflow_r   <= 1'b0;
    end else begin
      if (ctl.needle) begin
        if (needle_full) begin
          overflow_r <= 1'b1;
        end else begin
          needle_len_r <= needle_len_r + 1'b1;
        end
      end
      if (ctl.hay) begin
        window_r[0] <= folded;
        for (int j = 1; j < NEEDLE_MAX; j++) begin
          window_r[j] <= window_r[j-1];
        end
        if (hay_count_r != '1) begin
          hay_count_r <= hay_count_r + 1'b1;
        end
      end
      if (ctl.commit) begin
        reported_r <= 1'b1;
      end
    end
  end

  // hold the delivered result
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_status_r   <= res_status;
      out_position_r <= res_position;
    end
  end

  assign out_status   = out_status_r;
  assign out_position = out_position_r;

  // needle length never passes the store depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    needle_len_r <= LEN_W'(NEEDLE_MAX))
    else $error("needle length beyond store depth");

endmodule

### src/folded_substring_search_top.sv
// Sequence: a hay or end-of-hay transaction is compared in the evaluate state
//   after acceptance; out_valid is registered and rises once that state commits a result.
// Flow: clear and needle transactions do not stall the input; hay and end
//   transactions hold in_stall through the evaluate state of the window compare.
// Reset: synchronous on rst_n low; clears the job, the hay window and the
//   output valid flag. The needle store is not cleared.
// ----------------------------------------------------------------------------
// folded_substring_search_top
// Case and accent insensitive Latin-1 substring search over a byte stream.
// ----------------------------------------------------------------------------
module folded_substring_search_top
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_position
);

  fss_ctl_t ctl;
  fss_sts_t sts;

  fss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ctl        (ctl),
    .sts        (sts)
  );

  fss_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte_value (in_byte_value),
    .ctl           (ctl),
    .sts           (sts),
    .out_status    (out_status),
    .out_position  (out_position)
  );

endmodule

### tb/folded_substring_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// folded_substring_search_checker
// Watches both channels of the search block, keeps its own copy of the job
// state, predicts the result of every accepted transaction and compares each
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module folded_substring_search_checker
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_position,
  output int          mismatch_count,
  output int          results_owed
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
  } search_result_t;

  // Latin-1 folding: merge case, strip most accents
  localparam logic [7:0] LATIN1_FOLD [256] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f,
    8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'h40, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'h7e, 8'h7f,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f,
    8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
    8'h20, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'h7c, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'h2d, 8'hae, 8'haf,
    8'hb0, 8'hb1, 8'h32, 8'h33, 8'h27, 8'hb5, 8'hb6, 8'h2e,
    8'hb8, 8'h31, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'h3f,
    8'h61, 8'h61, 8'h61, 8'h61, 8'he4, 8'he5, 8'he6, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h64, 8'h6e, 8'h6f, 8'h6f, 8'h6f, 8'h6f, 8'hf6, 8'h78,
    8'hf8, 8'h75, 8'h75, 8'h75, 8'hfc, 8'h79, 8'hfe, 8'hdf,
    8'h61, 8'h61, 8'h61, 8'h61, 8'he4, 8'he5, 8'he6, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h64, 8'h6e, 8'h6f, 8'h6f, 8'h6f, 8'h6f, 8'hf6, 8'hf7,
    8'hf8, 8'h75, 8'h75, 8'h75, 8'hfc, 8'h79, 8'hfe, 8'h79
  };

  // job state as the block should hold it
  logic [7:0]       needle_folded [NEEDLE_MAX];
  logic [LEN_W-1:0] needle_len;
  logic [7:0]       recent_hay [NEEDLE_MAX];
  logic [31:0]      hay_seen;
  logic             job_done;
  logic             needle_overflowed;

  search_result_t   awaited_results [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // drop the job: empty needle, zeroed window, no result given yet
  task automatic clear_search();
    needle_len        = '0;
    hay_seen          = '0;
    job_done          = 1'b0;
    needle_overflowed = 1'b0;
    foreach (recent_hay[k]) recent_hay[k] = 8'h00;
  endtask

  task automatic push_result(input logic [1:0] status, input logic [31:0] position);
    search_result_t res;
    res.status   = status;
    res.position = position;
    awaited_results.push_back(res);
    job_done = 1'b1;
  endtask

  // advance the job by one transaction, queue the result it causes
  task automatic apply_transaction(input logic [1:0] cmd, input logic [7:0] raw);
    logic [7:0] folded;
    logic       hit;
    folded = LATIN1_FOLD[raw];
    case (cmd)
      CMD_CLEAR: begin
        clear_search();
      end
      CMD_NEEDLE: begin
        if (needle_len < NEEDLE_MAX) begin
          needle_folded[needle_len] = folded;
          needle_len = needle_len + 1'b1;
        end else begin
          needle_overflowed = 1'b1;
        end
      end
      CMD_HAY: begin
        for (int k = NEEDLE_MAX - 1; k > 0; k--) recent_hay[k] = recent_hay[k - 1];
        recent_hay[0] = folded;
        if (hay_seen != 32'hffff_ffff) hay_seen = hay_seen + 1;
        if (!job_done && !needle_overflowed) begin
          if (needle_len == 0) begin
            push_result(ST_FOUND, 32'd0);
          end else if (hay_seen >= needle_len) begin
            hit = 1'b1;
            for (int k = 0; k < needle_len; k++)
              if (needle_folded[k] != recent_hay[needle_len - 1 - k]) hit = 1'b0;
            if (hit) push_result(ST_FOUND, hay_seen - 32'(needle_len));
          end
        end
      end
      default: begin
        if (!job_done) push_result(needle_overflowed ? ST_OVERFLOW : ST_NOT_FOUND, 32'd0);
      end
    endcase
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    search_result_t want;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual status %0d position %0d",
               $time, out_status, out_position);
      return;
    end
    want = awaited_results.pop_front();
    if (out_status !== want.status) begin
      mismatch_count++;
      $display("%0t: status mismatch, expected %0d, actual %0d",
               $time, want.status, out_status);
    end
    if (out_position !== want.position) begin
      mismatch_count++;
      $display("%0t: position mismatch, expected %0d, actual %0d",
               $time, want.position, out_position);
    end
  endtask

  // sample both channels at each edge; results always trail their transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_search();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) apply_transaction(in_command, in_byte_value);
    end
    results_owed = awaited_results.size();
  end

endmodule

### tb/folded_substring_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// folded_substring_search_top_tb
// Drives search jobs into the block: a directed pass over the special cases,
// then random jobs built from letters in several case and accent forms, with
// needles planted in the hay, plus noise. Random gaps on the sender and
// random stalls on the receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module folded_substring_search_top_tb;
  import fss_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int MIN_JOBS    = 20;

  // raw spellings of a, e, o and y that all fold together
  localparam logic [7:0] LETTER_FORMS [4][8] = '{
    '{8'h41, 8'h61, 8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'he0, 8'he1},
    '{8'h45, 8'h65, 8'hc8, 8'hc9, 8'hca, 8'hcb, 8'he8, 8'he9},
    '{8'h4f, 8'h6f, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hf2, 8'hf3},
    '{8'h59, 8'h79, 8'hdd, 8'hfd, 8'hff, 8'h79, 8'h59, 8'hff}
  };
  localparam int LITERAL = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_position;

  int mismatch_count;
  int results_owed;
  int items_sent;
  int jobs_run;
  int stall_run = 0;
  bit gaps_on;

  folded_substring_search_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_byte_value (in_byte_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_position  (out_position)
  );

  folded_substring_search_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_position   (out_position),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly short idle gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [7:0] letter_variant(input int grp);
    return LETTER_FORMS[grp][$urandom_range(0, 7)];
  endfunction

  // receiver side: alternate stall bursts and stall-free stretches
  always @(posedge clk) begin : stall_gen
    int len;
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 6);
    end else begin
      len = pick_gap();
      if (len == 0) begin
        stall_run <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b1;
        stall_run <= len - 1;
      end
    end
  end

  // present one transaction and hold it until accepted
  task automatic send(input logic [1:0] cmd, input logic [7:0] value);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_byte_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // one job: clear, needle, hay with the needle sometimes planted, usually an end; or a few random commands
  task automatic run_search_job();
    int         r;
    int         nlen;
    int         hlen;
    int         plant_at;
    int         grp;
    logic [7:0] b;
    int         grp_q [$];
    logic [7:0] raw_q [$];
    jobs_run++;
    gaps_on = ($urandom_range(0, 4) != 0);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6)) send(2'($urandom_range(0, 3)), 8'($urandom()));
      return;
    end
    send(CMD_CLEAR, 8'($urandom()));
    r = $urandom_range(0, 99);
    if (r < 10) nlen = 0;
    else if (r < 78) nlen = $urandom_range(1, 4);
    else if (r < 90) nlen = $urandom_range(5, NEEDLE_MAX);
    else nlen = $urandom_range(NEEDLE_MAX + 1, NEEDLE_MAX + 4);
    for (int i = 0; i < nlen; i++) begin
      grp = ($urandom_range(0, 4) == 0) ? LITERAL : $urandom_range(0, 3);
      b = (grp == LITERAL) ? 8'($urandom()) : letter_variant(grp);
      grp_q.push_back(grp);
      raw_q.push_back(b);
      send(CMD_NEEDLE, b);
    end
    hlen = $urandom_range(0, nlen + 12);
    plant_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, hlen) : -1;
    for (int i = 0; i <= hlen; i++) begin
      if (i == plant_at) begin
        for (int j = 0; j < nlen && j < NEEDLE_MAX; j++)
          send(CMD_HAY, (grp_q[j] == LITERAL) ? raw_q[j] : letter_variant(grp_q[j]));
      end
      if (i < hlen) begin
        // occasionally grow the needle in the middle of the hay
        if ($urandom_range(0, 19) == 0) send(CMD_NEEDLE, letter_variant($urandom_range(0, 3)));
        send(CMD_HAY, ($urandom_range(0, 6) == 0) ? 8'($urandom())
                                                  : letter_variant($urandom_range(0, 3)));
      end
    end
    if ($urandom_range(0, 9) != 0) send(CMD_END, 8'($urandom()));
    if ($urandom_range(0, 3) == 0) wait_for_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_CLEAR;
    in_byte_value = 8'h00;
    gaps_on       = 1'b1;
    items_sent    = 0;
    jobs_run      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // end of hay straight out of reset, then hay after the result
    send(CMD_END, 8'h00);
    send(CMD_HAY, 8'h00);
    // empty needle: first hay byte is found at zero
    send(CMD_CLEAR, 8'hff);
    send(CMD_HAY, 8'hff);
    send(CMD_HAY, 8'h41);
    // short hay with a zero byte in the needle: not found
    send(CMD_CLEAR, 8'h00);
    send(CMD_NEEDLE, 8'hc4);
    send(CMD_NEEDLE, 8'h00);
    send(CMD_HAY, 8'he4);
    send(CMD_END, 8'h00);
    // accent and case folded match at offset one, later traffic ignored
    send(CMD_CLEAR, 8'h00);
    send(CMD_NEEDLE, 8'h41);
    send(CMD_NEEDLE, 8'hff);
    send(CMD_HAY, 8'h58);
    send(CMD_HAY, 8'he0);
    send(CMD_HAY, 8'h59);
    send(CMD_HAY, 8'h61);
    send(CMD_END, 8'hff);
    // needle grown after hay has started
    send(CMD_CLEAR, 8'h00);
    send(CMD_NEEDLE, 8'h42);
    send(CMD_HAY, 8'h78);
    send(CMD_NEEDLE, 8'h63);
    send(CMD_HAY, 8'h62);
    send(CMD_HAY, 8'h43);
    send(CMD_END, 8'h00);
    wait_for_results();

    items_sent = 0;
    while (items_sent < ITEM_TARGET || jobs_run < MIN_JOBS) run_search_job();
    wait_for_results();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
